/* src/srsf_pkg.sv */
// Shared types, constants and lookup tables of the SID register SysEx framer.
package srsf_pkg;

   // Build-time defaults and geometry
   localparam int NUM_CHIPS_DEF = 2;
   localparam int NREGS         = 25;
   localparam int MAX_ADDR      = 24;
   localparam int REG_W         = 5;
   localparam int MASK_W        = 28;
   localparam int PAIR_LIMIT    = 8;

   // Opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Frame bytes
   localparam logic [7:0] SYX_START  = 8'hF0;
   localparam logic [7:0] SYX_MFR_ID = 8'h2D;
   localparam logic [7:0] SYX_END    = 8'hF7;
   localparam logic [7:0] CMD_FULL0  = 8'h4E;
   localparam logic [7:0] CMD_FULL1  = 8'h50;
   localparam logic [7:0] CMD_PAIR0  = 8'h6C;
   localparam logic [7:0] CMD_PAIR1  = 8'h6D;
   localparam logic [7:0] VAL_MASK   = 8'h7F;

   // Input transaction
   typedef struct packed {
      logic       opcode;
      logic       chip_select;
      logic [4:0] reg_address;
      logic [7:0] data_byte;
   } srsf_req_type;

   // Output transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
   } srsf_rsp_type;

   // Implemented bits of each chip register
   function automatic logic [7:0] bit_mask(input logic [REG_W-1:0] r);
      logic [7:0] m;
      case (r)
         5'd3, 5'd10, 5'd17: m = 8'h0F;
         5'd21:              m = 8'h07;
         default:            m = 8'hFF;
      endcase
      return m;
   endfunction

   // Control registers force a flush when rewritten while pending
   function automatic logic is_ctrl_reg(input logic [REG_W-1:0] r);
      return (r == 5'd4) || (r == 5'd11) || (r == 5'd18);
   endfunction

   // Register address at each position of the full frame
   function automatic logic [REG_W-1:0] map_order(input logic [REG_W-1:0] i);
      logic [REG_W-1:0] r;
      case (i)
         5'd0:    r = 5'd0;
         5'd1:    r = 5'd1;
         5'd2:    r = 5'd2;
         5'd3:    r = 5'd3;
         5'd4:    r = 5'd5;
         5'd5:    r = 5'd6;
         5'd6:    r = 5'd7;
         5'd7:    r = 5'd8;
         5'd8:    r = 5'd9;
         5'd9:    r = 5'd10;
         5'd10:   r = 5'd12;
         5'd11:   r = 5'd13;
         5'd12:   r = 5'd14;
         5'd13:   r = 5'd15;
         5'd14:   r = 5'd16;
         5'd15:   r = 5'd17;
         5'd16:   r = 5'd19;
         5'd17:   r = 5'd20;
         5'd18:   r = 5'd21;
         5'd19:   r = 5'd22;
         5'd20:   r = 5'd23;
         5'd21:   r = 5'd24;
         5'd22:   r = 5'd4;
         5'd23:   r = 5'd11;
         5'd24:   r = 5'd18;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

/* src/srsf_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module srsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and register the read data; hold it while no read is issued
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* src/srsf_core.sv */
// Sequencer of the framer: compares and writes back shadow registers, builds frames.
module srsf_core #(
   parameter int NUM_CHIPS = srsf_pkg::NUM_CHIPS_DEF,
   parameter int CHIP_W    = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1,
   parameter int ADDR_W    = CHIP_W + srsf_pkg::REG_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pair_mode,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  srsf_pkg::srsf_req_type req_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output srsf_pkg::srsf_rsp_type out_data,
   output logic                  ram_wr_en,
   output logic [ADDR_W-1:0]     ram_wr_addr,
   output logic [7:0]            ram_wr_data,
   output logic                  ram_rd_en,
   output logic [ADDR_W-1:0]     ram_rd_addr,
   input  logic [7:0]            ram_rd_data
);

   import srsf_pkg::*;

   localparam logic [3:0] HDR_LAST_PAIR = 4'd2;
   localparam logic [3:0] HDR_LAST_FULL = 4'd10;

   typedef enum logic [3:0] {
      S_IDLE, S_CMP, S_INIT, S_HDR, S_SCAN, S_VAL0, S_VAL1, S_TAIL
   } state_type;

   state_type          state_ff, state_in;
   logic [CHIP_W-1:0]  chip_ff, chip_in;
   logic [REG_W-1:0]   reg_ff, reg_in;
   logic [7:0]         data_ff, data_in;
   logic               after_ff, after_in;
   logic               pair_ff, pair_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [MASK_W-1:0]  msbs_ff, msbs_in;
   logic [3:0]         hdr_ff, hdr_in;
   logic [REG_W-1:0]   idx_ff, idx_in;
   logic [REG_W-1:0]   sel_ff, sel_in;
   logic [NREGS-1:0]   pend_ff [NUM_CHIPS];
   logic [NREGS-1:0]   pend_in [NUM_CHIPS];
   logic [NREGS-1:0]   vld_ff  [NUM_CHIPS];
   logic [NREGS-1:0]   vld_in  [NUM_CHIPS];
   logic [NREGS-1:0]   msb_ff  [NUM_CHIPS];
   logic [NREGS-1:0]   msb_in  [NUM_CHIPS];
   logic [REG_W-1:0]   cnt_ff  [NUM_CHIPS];
   logic [REG_W-1:0]   cnt_in  [NUM_CHIPS];

   logic               chip_ok;
   logic [CHIP_W-1:0]  req_chip;
   logic [7:0]         masked;
   logic [7:0]         old_val;
   logic [7:0]         cur_val;
   logic [REG_W-1:0]   scan_reg;
   logic [REG_W-1:0]   map_reg;
   logic               do_write;
   logic               flush_first;
   logic [7:0]         cmd_byte;

   // Decode the incoming item and the shadow value read back
   always_comb begin
      chip_ok  = 32'(req_data.chip_select) < 32'(NUM_CHIPS);
      req_chip = CHIP_W'(req_data.chip_select);
      masked   = data_ff & bit_mask(reg_ff);
      old_val  = vld_ff[chip_ff][reg_ff] ? ram_rd_data : 8'h00;
      cur_val  = vld_ff[chip_ff][sel_ff] ? ram_rd_data : 8'h00;
      scan_reg = pair_ff ? idx_ff : map_order(idx_ff);
      flush_first = (is_ctrl_reg(reg_ff) || pair_mode) && pend_ff[chip_ff][reg_ff];
      if (pair_ff) begin
         cmd_byte = (chip_ff == '0) ? CMD_PAIR0 : CMD_PAIR1;
      end else begin
         cmd_byte = (chip_ff == '0) ? CMD_FULL0 : CMD_FULL1;
      end
   end

   // Next state, frame sequencing and shadow bookkeeping
   always_comb begin
      state_in = state_ff;
      chip_in  = chip_ff;
      reg_in   = reg_ff;
      data_in  = data_ff;
      after_in = after_ff;
      pair_in  = pair_ff;
      mask_in  = mask_ff;
      msbs_in  = msbs_ff;
      hdr_in   = hdr_ff;
      idx_in   = idx_ff;
      sel_in   = sel_ff;
      pend_in  = pend_ff;
      vld_in   = vld_ff;
      msb_in   = msb_ff;
      cnt_in   = cnt_ff;
      map_reg  = '0;
      do_write = 1'b0;

      req_ready   = 1'b0;
      out_valid   = 1'b0;
      out_data    = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = {chip_ff, scan_reg};

      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            ram_rd_addr = {req_chip, req_data.reg_address};
            if (req_valid) begin
               chip_in  = req_chip;
               reg_in   = req_data.reg_address;
               data_in  = req_data.data_byte;
               after_in = 1'b0;
               if (chip_ok) begin
                  if (req_data.opcode == OP_FLUSH) begin
                     if (cnt_ff[req_chip] != '0) begin
                        state_in = S_INIT;
                     end
                  end else if (req_data.reg_address <= REG_W'(MAX_ADDR)) begin
                     ram_rd_en = 1'b1;
                     state_in  = S_CMP;
                  end
               end
            end
         end
         S_CMP: begin
            if (masked == old_val) begin
               state_in = S_IDLE;
            end else if (flush_first) begin
               after_in = 1'b1;
               state_in = S_INIT;
            end else begin
               do_write = 1'b1;
               if (!pend_ff[chip_ff][reg_ff]) begin
                  cnt_in[chip_ff] = cnt_ff[chip_ff] + 1'b1;
               end
               pend_in[chip_ff][reg_ff] = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_INIT: begin
            // Snapshot frame kind, presence mask and MSB set
            pair_in = pair_mode && (cnt_ff[chip_ff] < REG_W'(PAIR_LIMIT));
            mask_in = '0;
            msbs_in = '0;
            for (int i = 0; i < NREGS; i++) begin
               map_reg    = map_order(REG_W'(i));
               mask_in[i] = pend_ff[chip_ff][map_reg];
               msbs_in[i] = pend_ff[chip_ff][map_reg] & msb_ff[chip_ff][map_reg];
            end
            hdr_in   = '0;
            state_in = S_HDR;
         end
         S_HDR: begin
            out_valid = 1'b1;
            case (hdr_ff)
               4'd0:    out_data.out_byte = SYX_START;
               4'd1:    out_data.out_byte = SYX_MFR_ID;
               4'd2:    out_data.out_byte = cmd_byte;
               4'd3:    out_data.out_byte = {1'b0, mask_ff[6:0]};
               4'd4:    out_data.out_byte = {1'b0, mask_ff[13:7]};
               4'd5:    out_data.out_byte = {1'b0, mask_ff[20:14]};
               4'd6:    out_data.out_byte = {1'b0, mask_ff[27:21]};
               4'd7:    out_data.out_byte = {1'b0, msbs_ff[6:0]};
               4'd8:    out_data.out_byte = {1'b0, msbs_ff[13:7]};
               4'd9:    out_data.out_byte = {1'b0, msbs_ff[20:14]};
               4'd10:   out_data.out_byte = {1'b0, msbs_ff[27:21]};
               default: out_data.out_byte = SYX_START;
            endcase
            if (out_ready) begin
               if (hdr_ff == (pair_ff ? HDR_LAST_PAIR : HDR_LAST_FULL)) begin
                  idx_in   = '0;
                  state_in = S_SCAN;
               end else begin
                  hdr_in = hdr_ff + 1'b1;
               end
            end
         end
         S_SCAN: begin
            // Walk the registers; read the next pending one
            if (idx_ff == REG_W'(NREGS)) begin
               state_in = S_TAIL;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (pend_ff[chip_ff][scan_reg]) begin
                  ram_rd_en = 1'b1;
                  sel_in    = scan_reg;
                  state_in  = S_VAL0;
               end
            end
         end
         S_VAL0: begin
            out_valid = 1'b1;
            if (pair_ff) begin
               out_data.out_byte = {1'b0, cur_val[7], 1'b0, sel_ff};
            end else begin
               out_data.out_byte = cur_val & VAL_MASK;
            end
            if (out_ready) begin
               state_in = pair_ff ? S_VAL1 : S_SCAN;
            end
         end
         S_VAL1: begin
            out_valid         = 1'b1;
            out_data.out_byte = cur_val & VAL_MASK;
            if (out_ready) begin
               state_in = S_SCAN;
            end
         end
         S_TAIL: begin
            out_valid          = 1'b1;
            out_data.out_byte  = SYX_END;
            out_data.frame_end = 1'b1;
            if (out_ready) begin
               // Clear the chip's pending set; apply a deferred write
               pend_in[chip_ff] = '0;
               cnt_in[chip_ff]  = '0;
               if (after_ff) begin
                  do_write = 1'b1;
                  pend_in[chip_ff][reg_ff] = 1'b1;
                  cnt_in[chip_ff] = REG_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Write back the shadow entry
      ram_wr_en   = do_write;
      ram_wr_addr = {chip_ff, reg_ff};
      ram_wr_data = masked;
      if (do_write) begin
         vld_in[chip_ff][reg_ff] = 1'b1;
         msb_in[chip_ff][reg_ff] = masked[7];
      end
   end

   // Hold state and registered bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int c = 0; c < NUM_CHIPS; c++) begin
            pend_ff[c] <= '1;
            vld_ff[c]  <= '0;
            msb_ff[c]  <= '0;
            cnt_ff[c]  <= REG_W'(NREGS);
         end
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         vld_ff   <= vld_in;
         msb_ff   <= msb_in;
         cnt_ff   <= cnt_in;
      end
      chip_ff  <= chip_in;
      reg_ff   <= reg_in;
      data_ff  <= data_in;
      after_ff <= after_in;
      pair_ff  <= pair_in;
      mask_ff  <= mask_in;
      msbs_ff  <= msbs_in;
      hdr_ff   <= hdr_in;
      idx_ff   <= idx_in;
      sel_ff   <= sel_in;
   end

endmodule

/* src/sid_register_sysex_framer_unit.sv */
// Top level of the SID register SysEx framer: config register, shadow RAM, output stage.
//
// Keeps a shadow of the 25 registers of each sound chip in a RAM and turns
// changed registers into SysEx update frames, one byte per rsp transaction,
// with frame_end set on the closing F7. A register write is accepted with the
// shadow read, then compared and written back, unless it first flushes a
// pending frame; a write above address 24 or a flush with nothing pending
// ends at acceptance. During a flush the sequencer walks all 25 register
// slots, each pending one costing a shadow RAM read through its single read
// port, and sends the frame bytes as the output stage takes them; no new
// request is accepted until the closing F7 has entered the output stage.
// Shadow entries never written read as zero through per-entry valid flops,
// so reset needs no clearing pass. The pair mode register is written through
// csr_wr_en/csr_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce.
module sid_register_sysex_framer_unit #(
   parameter int NUM_CHIPS = srsf_pkg::NUM_CHIPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  srsf_pkg::srsf_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output srsf_pkg::srsf_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data
);

   import srsf_pkg::*;

   localparam int CHIP_W = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
   localparam int ADDR_W = CHIP_W + REG_W;
   localparam int DEPTH  = 2 ** ADDR_W;

   logic              pair_mode_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   srsf_rsp_type      rsp_data_ff, rsp_data_in;
   logic              core_valid;
   logic              core_ready;
   srsf_rsp_type      core_data;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   // Hold the pair mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         pair_mode_ff <= csr_wr_data;
      end
   end

   // Output register: load when empty or being drained
   always_comb begin
      core_ready   = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (core_ready && core_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   srsf_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_shadow (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   srsf_core #(
      .NUM_CHIPS(NUM_CHIPS),
      .CHIP_W   (CHIP_W),
      .ADDR_W   (ADDR_W)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .pair_mode  (pair_mode_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .out_valid  (core_valid),
      .out_ready  (core_ready),
      .out_data   (core_data),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_en  (ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data)
   );

endmodule

/* test/sid_register_sysex_framer_unit_test.sv */
// Self-checking testbench for the SID register SysEx framer: directed rows, then random traffic.
module sid_register_sysex_framer_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import srsf_pkg::*;

   localparam int ITEMS_PER_PHASE = 92;
   localparam int SETTLE_CYCLES   = 100;

   // Register address carried at each slot of the full frame
   localparam logic [0:24][4:0] FRAME_SLOT = {
      5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd12, 5'd13, 5'd14,
      5'd15, 5'd16, 5'd17, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd4, 5'd11, 5'd18};

   // How a directed row is checked; pair_mode rows carry the value in data_byte bit 0
   typedef enum logic [1:0] {
      ROW_MODEL,
      ROW_QUIET,
      ROW_RESET_FRAME,
      ROW_PAIR_MODE
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      srsf_req_type item;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   srsf_req_type req_data;
   row_kind_type req_kind;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   srsf_rsp_type rsp_data;
   logic         csr_wr_en;
   logic         csr_wr_data;

   // Shadow of the block's state
   logic [7:0]   shadow [2][25];
   logic [24:0]  pending [2];
   bit           pair_mode;

   srsf_rsp_type     frame_bytes_due[$];
   directed_row_type directed_rows [25];
   int               fail_count = 0;
   int               sender_idle_pct = 0;
   int               stall_pct = 0;

   sid_register_sysex_framer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic void flag(input string msg);
      fail_count++;
      $error("%s", msg);
   endfunction

   function automatic logic [7:0] implemented_bits(input logic [4:0] r);
      if (r == 5'd3 || r == 5'd10 || r == 5'd17) return 8'h0F;
      if (r == 5'd21) return 8'h07;
      return 8'hFF;
   endfunction

   function automatic void emit_byte(input logic [7:0] b, input bit last, input bit record);
      srsf_rsp_type r;
      r.out_byte  = b;
      r.frame_end = last;
      if (record) frame_bytes_due.push_back(r);
   endfunction

   // Pack the pending registers of one chip into a frame, then clear them
   function automatic void pack_frame(input bit chip, input bit record);
      int         cnt;
      logic [27:0] present_mask;
      logic [27:0] top_bits;
      logic [7:0] v;
      logic [4:0] r;
      if (pending[chip] == '0) return;
      cnt = $countones(pending[chip]);
      emit_byte(SYX_START, 1'b0, record);
      emit_byte(SYX_MFR_ID, 1'b0, record);
      if (pair_mode && (2 * cnt + 4 < cnt + 12)) begin
         emit_byte(chip ? CMD_PAIR1 : CMD_PAIR0, 1'b0, record);
         for (int i = 0; i < NREGS; i++) begin
            if (pending[chip][i]) begin
               v = shadow[chip][i];
               emit_byte(8'(i) | (v[7] ? 8'h40 : 8'h00), 1'b0, record);
               emit_byte(v & VAL_MASK, 1'b0, record);
            end
         end
      end else begin
         emit_byte(chip ? CMD_FULL1 : CMD_FULL0, 1'b0, record);
         present_mask = '0;
         top_bits     = '0;
         for (int i = 0; i < NREGS; i++) begin
            r = FRAME_SLOT[i];
            if (pending[chip][r]) begin
               present_mask[i] = 1'b1;
               top_bits[i]     = shadow[chip][r][7];
            end
         end
         for (int k = 0; k < 4; k++) emit_byte({1'b0, present_mask[7*k +: 7]}, 1'b0, record);
         for (int k = 0; k < 4; k++) emit_byte({1'b0, top_bits[7*k +: 7]}, 1'b0, record);
         for (int i = 0; i < NREGS; i++) begin
            r = FRAME_SLOT[i];
            if (pending[chip][r]) emit_byte(shadow[chip][r] & VAL_MASK, 1'b0, record);
         end
      end
      emit_byte(SYX_END, 1'b1, record);
      pending[chip] = '0;
   endfunction

   // Advance the shadow state by one transaction and queue the frame bytes it causes
   function automatic void predict_frame_bytes(input srsf_req_type t, input bit record);
      logic [7:0] v;
      if (t.opcode == OP_FLUSH) begin
         pack_frame(t.chip_select, record);
         return;
      end
      if (t.reg_address > MAX_ADDR) return;
      v = t.data_byte & implemented_bits(t.reg_address);
      if (shadow[t.chip_select][t.reg_address] == v) return;
      if ((t.reg_address == 5'd4 || t.reg_address == 5'd11 || t.reg_address == 5'd18 ||
           pair_mode) && pending[t.chip_select][t.reg_address])
         pack_frame(t.chip_select, record);
      shadow[t.chip_select][t.reg_address]  = v;
      pending[t.chip_select][t.reg_address] = 1'b1;
   endfunction

   // Mostly real register traffic with random flushes; some noise on top
   function automatic srsf_req_type random_request();
      srsf_req_type t;
      int           pick;
      t.opcode      = OP_WRITE;
      t.chip_select = 1'($urandom_range(1));
      t.reg_address = 5'($urandom_range(31));
      t.data_byte   = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 18) begin
         t.opcode = OP_FLUSH;
      end else begin
         if (pick < 30) begin
            case ($urandom_range(2))
               0:       t.reg_address = 5'd4;
               1:       t.reg_address = 5'd11;
               default: t.reg_address = 5'd18;
            endcase
         end else if (pick < 92) begin
            t.reg_address = 5'($urandom_range(MAX_ADDR));
         end
         // rewrite the current value now and then
         if (t.reg_address <= MAX_ADDR && $urandom_range(9) == 0)
            t.data_byte = shadow[t.chip_select][t.reg_address];
      end
      return t;
   endfunction

   // Receiver stall
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   // Check result transactions, then record the input transaction accepted at this edge
   always @(posedge clock) begin
      srsf_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_due.size() == 0) begin
               flag($sformatf("rsp transaction with no frame byte due: out_byte %02h",
                              rsp_data.out_byte));
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  flag($sformatf("out_byte: expected %02h, got %02h",
                                 want.out_byte, rsp_data.out_byte));
               if (rsp_data.frame_end !== want.frame_end)
                  flag($sformatf("frame_end: expected %0b, got %0b",
                                 want.frame_end, rsp_data.frame_end));
            end
         end
         if (req_valid && req_ready) begin
            case (req_kind)
               ROW_QUIET: predict_frame_bytes(req_data, 1'b0);
               ROW_RESET_FRAME: begin
                  // all 25 registers pending, all zero
                  emit_byte(SYX_START, 1'b0, 1'b1);
                  emit_byte(SYX_MFR_ID, 1'b0, 1'b1);
                  emit_byte(req_data.chip_select ? CMD_FULL1 : CMD_FULL0, 1'b0, 1'b1);
                  for (int k = 0; k < 3; k++) emit_byte(8'h7F, 1'b0, 1'b1);
                  emit_byte(8'h0F, 1'b0, 1'b1);
                  for (int k = 0; k < 29; k++) emit_byte(8'h00, 1'b0, 1'b1);
                  emit_byte(SYX_END, 1'b1, 1'b1);
                  predict_frame_bytes(req_data, 1'b0);
               end
               default: predict_frame_bytes(req_data, 1'b1);
            endcase
         end
      end
   end

   task automatic send_item(input srsf_req_type item, input row_kind_type kind);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      req_kind  <= kind;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold off the sender until every frame byte has arrived and the block has settled
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_pair_mode(input bit value);
      wait_for_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pair_mode = value;
   endtask

   // Run limit
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      req_kind    <= ROW_MODEL;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= 1'b0;
      for (int c = 0; c < 2; c++) begin
         for (int i = 0; i < NREGS; i++) shadow[c][i] = 8'h00;
         pending[c] = '1;
      end
      pair_mode = 1'b0;

      directed_rows = '{
         '{ROW_PAIR_MODE,   '{OP_WRITE, 1'b0, 5'd0,  8'h00}},
         '{ROW_RESET_FRAME, '{OP_FLUSH, 1'b0, 5'd0,  8'h00}},
         '{ROW_QUIET,       '{OP_FLUSH, 1'b0, 5'd31, 8'hFF}},
         '{ROW_QUIET,       '{OP_WRITE, 1'b0, 5'd31, 8'hFF}},
         '{ROW_QUIET,       '{OP_WRITE, 1'b0, 5'd25, 8'h55}},
         '{ROW_QUIET,       '{OP_WRITE, 1'b0, 5'd0,  8'h00}},
         '{ROW_QUIET,       '{OP_WRITE, 1'b0, 5'd3,  8'hF0}},
         '{ROW_QUIET,       '{OP_WRITE, 1'b0, 5'd21, 8'hF8}},
         '{ROW_MODEL,       '{OP_WRITE, 1'b0, 5'd24, 8'hFF}},
         '{ROW_MODEL,       '{OP_WRITE, 1'b0, 5'd4,  8'h81}},
         '{ROW_MODEL,       '{OP_WRITE, 1'b0, 5'd4,  8'h41}},
         '{ROW_MODEL,       '{OP_WRITE, 1'b0, 5'd0,  8'h80}},
         '{ROW_MODEL,       '{OP_WRITE, 1'b0, 5'd0,  8'h7F}},
         '{ROW_MODEL,       '{OP_FLUSH, 1'b0, 5'd31, 8'hFF}},
         '{ROW_RESET_FRAME, '{OP_FLUSH, 1'b1, 5'd0,  8'h00}},
         '{ROW_PAIR_MODE,   '{OP_WRITE, 1'b0, 5'd0,  8'h01}},
         '{ROW_MODEL,       '{OP_WRITE, 1'b1, 5'd11, 8'h80}},
         '{ROW_MODEL,       '{OP_WRITE, 1'b1, 5'd17, 8'h3F}},
         '{ROW_MODEL,       '{OP_FLUSH, 1'b1, 5'd0,  8'h00}},
         '{ROW_MODEL,       '{OP_WRITE, 1'b1, 5'd2,  8'h12}},
         '{ROW_MODEL,       '{OP_WRITE, 1'b1, 5'd2,  8'h34}},
         '{ROW_MODEL,       '{OP_WRITE, 1'b1, 5'd21, 8'hFF}},
         '{ROW_MODEL,       '{OP_FLUSH, 1'b1, 5'd31, 8'h00}},
         '{ROW_QUIET,       '{OP_FLUSH, 1'b1, 5'd0,  8'hFF}},
         '{ROW_MODEL,       '{OP_WRITE, 1'b0, 5'd18, 8'hFF}}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed rows
      sender_idle_pct = 15;
      stall_pct       = 15;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_PAIR_MODE)
            set_pair_mode(directed_rows[i].item.data_byte[0]);
         else
            send_item(directed_rows[i].item, directed_rows[i].kind);
      end

      // Random phases: alternate pair mode, vary idling on both sides
      for (int p = 0; p < 5; p++) begin
         set_pair_mode(p[0] == 1'b0);
         case (p)
            0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
            1:       begin sender_idle_pct = 49; stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  stall_pct = 49; end
            default: begin sender_idle_pct = 15; stall_pct = 15; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == ITEMS_PER_PHASE / 2) wait_for_quiet();
            send_item(random_request(), ROW_MODEL);
         end
      end

      wait_for_quiet();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
